// ===== src/assert_macros.svh =====
// Assertion helper macros, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KTL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KTL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define KTL_ASSERT(label, clk, rst_n, prop, msg)
`define KTL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/ktl_pkg.sv =====
// ----------------------------------------------------------------------------
// ktl_pkg
// Shared constants and types for the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package ktl_pkg;
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNotUsed = 2'd1;
  localparam logic [1:0] StOrder   = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;
  localparam logic       CmdAdd    = 1'b0;
  localparam logic       CmdSample = 1'b1;
  localparam logic       KindScale = 1'b0;
  localparam logic       KindPos   = 1'b1;
  localparam logic [31:0] OneQ16   = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;
endpackage
`default_nettype wire

// ===== src/keyframe_track_lerp.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_lerp
// Per-track keyframe lists with linear interpolation between keys.
// ----------------------------------------------------------------------------
// One request is handled at a time; requests stall while one is in flight.
// After reset the key counts are cleared one list per cycle, which stalls
// requests until every list is cleared. A sample of an empty track and any
// request on a track not in use go straight to the result; the first key of
// a list is written without a read, and any other add first reads the last
// key of the list to check order and room. A sample issues and checks one
// key slot at a time until the first key past the time (up to MAX_KEYS
// slots), reads the earlier key, runs a 40-step serial divide and does
// three multiplies one per cycle. A stalled result holds the block, which
// returns to idle after each result.
// The key memory needs no clearing; only slots below a list's count are read.
`default_nettype none
`include "assert_macros.svh"
module keyframe_track_lerp #(
  parameter int unsigned MAX_TRACKS     = 64,
  parameter int unsigned MAX_KEYS       = 64,
  parameter int unsigned TIME_FRAC_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire logic               kind_i,
  input  wire logic [5:0]         track_i,
  input  wire logic [23:0]        frame_time_i,
  input  wire logic signed [31:0] value_x_i,
  input  wire logic signed [31:0] value_y_i,
  input  wire logic signed [31:0] value_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o
);
  localparam int unsigned TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned LW = TW + 1;
  localparam int unsigned KW = $clog2(MAX_KEYS);
  localparam int unsigned CW = KW + 1;
  localparam int unsigned AW = LW + KW;
  localparam int unsigned LISTS = 1 << LW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned TSW = 24;
  localparam int unsigned FRW = TSW - TIME_FRAC_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_ADDRD, S_ADDWR, S_SCAN, S_PREV, S_DIV, S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  // key memory: frame and vector of each slot in one word
  logic [FRW+95:0]     key_mem [DEPTH];
  logic [FRW-1:0]      frame_rd_q;
  ktl_pkg::vec_t       value_rd_q;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;

  // key count memory, one entry per list
  logic [CW-1:0] count_mem [LISTS];
  logic [CW-1:0] count_rd_q;
  logic [LW-1:0] cnt_addr;
  logic          cnt_we;
  logic [CW-1:0] cnt_wdata;
  logic [LW-1:0] clr_q;

  logic [6:0]    tracks_q;

  logic          cmd_q, kind_q;
  logic [5:0]    track_q;
  logic [23:0]   time_q;
  ktl_pkg::vec_t vin_q;
  logic [LW-1:0] list_q;
  logic [CW-1:0] n_q, idx_q;
  logic [FRW-1:0] kb_q;
  ktl_pkg::vec_t b_q, a_q, res_q;
  logic [1:0]    status_q;
  logic [1:0]    comp_q;
  logic          rd_pend_q;
  logic          div_start_q;
  logic [TSW-1:0] div_num, div_den;
  logic          div_done;
  logic [15:0]   frac;

  logic [10:0]   limit;
  logic          in_use;
  logic [TSW-1:0] ka_t, kb_t;
  logic          out_held;

  assign limit  = (11'(tracks_q) < 11'(MAX_TRACKS)) ? 11'(tracks_q) : 11'(MAX_TRACKS);
  assign in_use = 11'(track_q) < limit;
  assign in_stall_o = (state_q != S_IDLE);
  assign ka_t = TSW'(frame_rd_q) << TIME_FRAC_BITS;
  assign kb_t = TSW'(kb_q) << TIME_FRAC_BITS;
  assign div_num = time_q - ka_t;
  assign div_den = kb_t - ka_t;
  assign out_held = out_valid_o && out_stall_i;

  always_comb begin
    mem_we   = (state_q == S_ADDWR);
    mem_addr = {list_q, idx_q[KW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_addr] <= {time_q[23:TIME_FRAC_BITS], vin_q};
    end
    {frame_rd_q, value_rd_q} <= key_mem[mem_addr];
  end

  // read the count of the waiting request while idle so it is ready at check
  always_comb begin
    cnt_we    = (state_q == S_CLEAR) || (state_q == S_ADDWR);
    cnt_wdata = (state_q == S_CLEAR) ? '0 : n_q + CW'(1);
    if (state_q == S_CLEAR) cnt_addr = clr_q;
    else if (state_q == S_IDLE) cnt_addr = {kind_i, TW'(track_i)};
    else cnt_addr = list_q;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[cnt_addr] <= cnt_wdata;
    end
    count_rd_q <= count_mem[cnt_addr];
  end

  ktl_divider #(.W(TSW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(frac)
  );

  // lerp of one component selected by comp_q
  logic signed [31:0] ca, cb;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  always_comb begin
    case (comp_q)
      2'd0:    begin ca = a_q.x; cb = b_q.x; end
      2'd1:    begin ca = a_q.y; cb = b_q.y; end
      default: begin ca = a_q.z; cb = b_q.z; end
    endcase
    diff = 33'(cb) - 33'(ca);
    prod = 50'(diff) * $signed({34'd0, frac});
  end
  logic signed [31:0] lerp_c;
  assign lerp_c = 32'(ca + 32'(prod >>> 16));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
      tracks_q    <= 7'd64;
      rd_pend_q   <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= (state_q == S_PREV) && rd_pend_q;
      if (cfg_we_i) tracks_q <= cfg_wdata_i;
      if (out_valid_o && !out_stall_i && state_q != S_OUT) out_valid_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + LW'(1);
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: if (in_valid_i) begin
          cmd_q <= cmd_i; kind_q <= kind_i; track_q <= track_i;
          time_q <= frame_time_i;
          vin_q <= '{value_x_i, value_y_i, value_z_i};
          list_q <= {kind_i, TW'(track_i)};
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          n_q       <= count_rd_q;
          rd_pend_q <= 1'b0;
          status_q  <= in_use ? ktl_pkg::StOk : ktl_pkg::StNotUsed;
          idx_q     <= (cmd_q == ktl_pkg::CmdAdd && count_rd_q != '0) ?
                       count_rd_q - CW'(1) : '0;
          if (in_use && cmd_q == ktl_pkg::CmdSample && count_rd_q == '0 &&
              kind_q == ktl_pkg::KindScale) begin
            res_q <= '{ktl_pkg::OneQ16, ktl_pkg::OneQ16, ktl_pkg::OneQ16};
          end else begin
            res_q <= '0;
          end
          if (!in_use || (cmd_q == ktl_pkg::CmdSample && count_rd_q == '0)) begin
            state_q <= S_OUT;
          end else if (cmd_q == ktl_pkg::CmdSample) begin
            state_q <= S_SCAN;
          end else if (count_rd_q == '0) begin
            state_q <= S_ADDWR;
          end else begin
            state_q <= S_ADDRD;
          end
        end
        S_ADDRD: begin
          // wait for the read of the last key's frame
          if (!rd_pend_q) rd_pend_q <= 1'b1;
          else if (FRW'(time_q[23:TIME_FRAC_BITS]) <= frame_rd_q) begin
            status_q <= ktl_pkg::StOrder; state_q <= S_OUT;
          end else if (n_q >= CW'(MAX_KEYS)) begin
            status_q <= ktl_pkg::StFull; state_q <= S_OUT;
          end else begin
            idx_q <= n_q; state_q <= S_ADDWR;
          end
        end
        S_ADDWR: begin
          state_q <= S_OUT;
        end
        S_SCAN: begin
          if (!rd_pend_q) rd_pend_q <= 1'b1;
          else if ((TSW'(frame_rd_q) << TIME_FRAC_BITS) > time_q) begin
            if (idx_q == '0) begin
              res_q <= value_rd_q; state_q <= S_OUT;
            end else begin
              kb_q <= frame_rd_q; b_q <= value_rd_q;
              idx_q <= idx_q - CW'(1);
              rd_pend_q <= 1'b0;
              state_q <= S_PREV;
            end
          end else if (idx_q + CW'(1) == n_q) begin
            res_q <= value_rd_q; state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + CW'(1);
            rd_pend_q <= 1'b0;
          end
        end
        S_PREV: begin
          if (!rd_pend_q) rd_pend_q <= 1'b1;
          else begin
            a_q <= value_rd_q;
            state_q <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          comp_q <= 2'd0; state_q <= S_MUL;
        end
        S_MUL: begin
          case (comp_q)
            2'd0:    res_q.x <= lerp_c;
            2'd1:    res_q.y <= lerp_c;
            default: res_q.z <= lerp_c;
          endcase
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd2) state_q <= S_OUT;
        end
        S_OUT: if (!out_valid_o || !out_stall_i) begin
          out_valid_o <= 1'b1;
          status_o <= status_q;
          out_x_o <= res_q.x; out_y_o <= res_q.y; out_z_o <= res_q.z;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `KTL_ASSERT(a_one_req, clk_i, rst_ni, !(in_valid_i && !in_stall_o && state_q != S_IDLE), "busy")
  `KTL_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, div_done, state_q == S_MUL, "divider result dropped")
  `KTL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(status_o), "hold")
endmodule
`default_nettype wire

// ===== src/ktl_divider.sv =====
// ----------------------------------------------------------------------------
// ktl_divider
// Restoring divider producing a 17-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ktl_divider #(
  parameter int unsigned W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,   // numerator before the <<16
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [15:0]       quot_o   // saturated to 16 bits
);
  localparam int unsigned NW = W + 16;
  logic [NW-1:0] num_q, num_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  den_q;
  logic [16:0]   quo_q, quo_d;
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem_q[W-1:0], num_q[NW-1]};
    num_d   = num_q << 1;
    if (shifted >= {1'b0, den_q}) begin
      rem_d = shifted - {1'b0, den_q};
      quo_d = {quo_q[15:0], 1'b1};
    end else begin
      rem_d = shifted;
      quo_d = {quo_q[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 16'd0};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q[16] ? 16'hFFFF : quo_q[15:0];
endmodule
`default_nettype wire
